@@ rtl/prt_pkg.sv @@
`default_nettype none
package prt_pkg;

    localparam int unsigned KIND_W    = 2;
    localparam int unsigned ADDR_W    = 16;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned IDX_OUT_W = 4;
    localparam int unsigned MAX_EMIT  = 16;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_FIND   = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_SORT   = 2'd3
    } kind_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] peer_address;
        logic [TIME_W-1:0] expiry_time;
        logic [TIME_W-1:0] delivery_time;
        logic [TIME_W-1:0] current_time;
    } cmd_item_t;

    typedef struct packed {
        logic [IDX_OUT_W-1:0] entry_index;
        logic                 index_valid;
        logic                 table_changed;
        logic                 last_result;
    } rsp_item_t;

endpackage
`default_nettype wire

@@ rtl/prt_ctrl.sv @@
`default_nettype none
// Command sequencer. Find and clear walk the linked lists one entry per cycle;
// it carries all list pointers, and the datapath holds the entry contents.
module prt_ctrl #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned PW    = 5
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire prt_pkg::cmd_item_t   in_item,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output prt_pkg::rsp_item_t        out_item,
    // datapath command and status
    output logic                      dp_write,
    output logic [PW-2:0]             dp_widx,
    output logic [PW-2:0]             dp_ridx,
    input  wire logic                 dp_addr_hit,
    input  wire logic                 dp_expired,
    input  wire logic [31:0]          dp_key
);
    import prt_pkg::*;

    localparam logic [PW-1:0] NIL = PW'(DEPTH);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_FIND   = 8'b0000_0010,
        S_CLEAR  = 8'b0000_0100,
        S_SNEXT  = 8'b0000_1000,
        S_SCMP   = 8'b0001_0000,
        S_SWALK  = 8'b0010_0000,
        S_EMIT   = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic [PW-1:0] link_reg [DEPTH];
    logic [PW-1:0] link_next [DEPTH];
    logic [PW-1:0] free_head_reg, free_head_next;
    logic [PW-1:0] used_head_reg, used_head_next;
    logic [PW-1:0] cur_reg, cur_next;
    logic [PW-1:0] prev_reg, prev_next;
    logic [PW-1:0] pre_reg, pre_next;
    logic [PW-1:0] at_reg, at_next;
    logic [PW:0]   steps_reg, steps_next;
    logic [PW:0]   inner_reg, inner_next;
    logic [31:0]   key_reg, key_next;
    logic          changed_reg, changed_next;
    logic [PW:0]   emitted_reg, emitted_next;
    rsp_item_t     out_reg, out_next;
    logic          ov_reg, ov_next;

    function automatic logic is_entry(input logic [PW-1:0] v);
        return v < PW'(DEPTH);
    endfunction

    assign in_stall  = (state_reg != S_IDLE) || ov_reg;
    assign out_valid = ov_reg;
    assign out_item  = out_reg;

    always_comb
    begin
        logic [PW-1:0] nxt;
        logic [PW-1:0] pick;
        logic          done;
        state_next     = state_reg;
        link_next      = link_reg;
        free_head_next = free_head_reg;
        used_head_next = used_head_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        pre_next       = pre_reg;
        at_next        = at_reg;
        steps_next     = steps_reg;
        inner_next     = inner_reg;
        key_next       = key_reg;
        changed_next   = changed_reg;
        emitted_next   = emitted_reg;
        out_next       = out_reg;
        ov_next        = ov_reg;
        dp_write       = 1'b0;
        dp_widx        = free_head_reg[PW-2:0];
        dp_ridx        = cur_reg[PW-2:0];
        nxt            = NIL;
        pick           = NIL;
        done           = 1'b0;
        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !ov_reg)
                begin
                    cur_next     = used_head_reg;
                    prev_next    = NIL;
                    steps_next   = '0;
                    changed_next = 1'b0;
                    emitted_next = '0;
                    case (kind_t'(in_item.kind))
                        KIND_INSERT:
                        begin
                            out_next = '0;
                            out_next.last_result = 1'b1;
                            if (is_entry(free_head_reg))
                            begin
                                dp_write = 1'b1;
                                link_next[free_head_reg[PW-2:0]] = used_head_reg;
                                used_head_next = free_head_reg;
                                free_head_next = link_reg[free_head_reg[PW-2:0]];
                                out_next.entry_index = IDX_OUT_W'(free_head_reg);
                                out_next.index_valid = 1'b1;
                            end
                            ov_next = 1'b1;
                        end
                        KIND_FIND:  state_next = S_FIND;
                        KIND_CLEAR: state_next = S_CLEAR;
                        KIND_SORT:
                        begin
                            if (is_entry(used_head_reg))
                            begin
                                cur_next = link_reg[used_head_reg[PW-2:0]];
                                link_next[used_head_reg[PW-2:0]] = NIL;
                                state_next = S_SNEXT;
                            end
                            else
                            begin
                                state_next = S_EMIT;
                            end
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_FIND:
            begin
                // dp_addr_hit compares the entry at cur_reg.
                if (steps_reg >= (PW+1)'(DEPTH) || !is_entry(cur_reg))
                begin
                    out_next = '0;
                    out_next.last_result = 1'b1;
                    done = 1'b1;
                end
                else if (dp_addr_hit)
                begin
                    out_next = '0;
                    out_next.entry_index = IDX_OUT_W'(cur_reg);
                    out_next.index_valid = 1'b1;
                    out_next.last_result = 1'b1;
                    done = 1'b1;
                end
                else
                begin
                    cur_next   = link_reg[cur_reg[PW-2:0]];
                    steps_next = steps_reg + 1'b1;
                end
                if (done)
                begin
                    state_next = S_OUT;
                end
            end
            S_CLEAR:
            begin
                if (steps_reg >= (PW+1)'(DEPTH) || !is_entry(cur_reg))
                begin
                    out_next = '0;
                    out_next.table_changed = changed_reg;
                    out_next.last_result = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    nxt = link_reg[cur_reg[PW-2:0]];
                    if (dp_expired)
                    begin
                        if (is_entry(prev_reg))
                        begin
                            link_next[prev_reg[PW-2:0]] = nxt;
                        end
                        else
                        begin
                            used_head_next = nxt;
                        end
                        link_next[cur_reg[PW-2:0]] = free_head_reg;
                        free_head_next = cur_reg;
                        changed_next = 1'b1;
                    end
                    else
                    begin
                        prev_next = cur_reg;
                    end
                    cur_next   = nxt;
                    steps_next = steps_reg + 1'b1;
                end
            end
            S_SNEXT:
            begin
                // Fetch the key of cur; used_head_reg is the sorted head.
                if (steps_reg >= (PW+1)'(DEPTH) || !is_entry(cur_reg))
                begin
                    cur_next   = used_head_reg;
                    state_next = S_EMIT;
                end
                else
                begin
                    key_next   = dp_key;
                    at_next    = used_head_reg;
                    state_next = S_SCMP;
                end
            end
            S_SCMP:
            begin
                // Datapath reads at_reg (the head) here.
                dp_ridx = at_reg[PW-2:0];
                nxt = link_reg[cur_reg[PW-2:0]];
                if (key_reg <= dp_key)
                begin
                    link_next[cur_reg[PW-2:0]] = used_head_reg;
                    used_head_next = cur_reg;
                    cur_next   = nxt;
                    steps_next = steps_reg + 1'b1;
                    state_next = S_SNEXT;
                end
                else
                begin
                    pre_next   = used_head_reg;
                    at_next    = link_reg[used_head_reg[PW-2:0]];
                    inner_next = '0;
                    state_next = S_SWALK;
                end
            end
            S_SWALK:
            begin
                dp_ridx = at_reg[PW-2:0];
                if (inner_reg < (PW+1)'(DEPTH) && is_entry(at_reg) && key_reg > dp_key)
                begin
                    pre_next   = at_reg;
                    at_next    = link_reg[at_reg[PW-2:0]];
                    inner_next = inner_reg + 1'b1;
                end
                else
                begin
                    nxt = link_reg[cur_reg[PW-2:0]];
                    link_next[cur_reg[PW-2:0]] = at_reg;
                    link_next[pre_reg[PW-2:0]] = cur_reg;
                    cur_next   = nxt;
                    steps_next = steps_reg + 1'b1;
                    state_next = S_SNEXT;
                end
            end
            S_EMIT:
            begin
                if (!ov_reg || !out_stall)
                begin
                    out_next = '0;
                    ov_next  = 1'b1;
                    if (!is_entry(cur_reg))
                    begin
                        out_next.last_result = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        pick = link_reg[cur_reg[PW-2:0]];
                        out_next.entry_index = IDX_OUT_W'(cur_reg);
                        out_next.index_valid = 1'b1;
                        if (!is_entry(pick) || emitted_reg + 1'b1 >= (PW+1)'(MAX_EMIT)
                            || emitted_reg + 1'b1 >= (PW+1)'(DEPTH))
                        begin
                            out_next.last_result = 1'b1;
                            state_next = S_IDLE;
                        end
                        cur_next     = pick;
                        emitted_next = emitted_reg + 1'b1;
                    end
                end
            end
            S_OUT:
            begin
                ov_next    = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            for (int i = 0; i < DEPTH; i++)
            begin
                link_reg[i] <= PW'(i + 1);
            end
            free_head_reg <= '0;
            used_head_reg <= NIL;
            ov_reg        <= 1'b0;
            cur_reg       <= NIL;
            prev_reg      <= NIL;
            pre_reg       <= NIL;
            at_reg        <= NIL;
            steps_reg     <= '0;
            inner_reg     <= '0;
            emitted_reg   <= '0;
            changed_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            link_reg      <= link_next;
            free_head_reg <= free_head_next;
            used_head_reg <= used_head_next;
            ov_reg        <= ov_next;
            cur_reg       <= cur_next;
            prev_reg      <= prev_next;
            pre_reg       <= pre_next;
            at_reg        <= at_next;
            steps_reg     <= steps_next;
            inner_reg     <= inner_next;
            emitted_reg   <= emitted_next;
            changed_reg   <= changed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        out_reg  <= out_next;
    end

endmodule
`default_nettype wire

@@ rtl/prt_dp.sv @@
`default_nettype none
// Entry contents and the comparators that the sequencer consults.
module prt_dp #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned PW    = 5
) (
    input  wire logic               clk,
    input  wire prt_pkg::cmd_item_t in_item,
    input  wire logic               write,
    input  wire logic [PW-2:0]      widx,
    input  wire logic [PW-2:0]      ridx,
    input  wire logic [15:0]        find_addr,
    input  wire logic [31:0]        now,
    output logic                    addr_hit,
    output logic                    expired,
    output logic [31:0]             key
);
    import prt_pkg::*;

    logic [ADDR_W-1:0] addr_mem [DEPTH];
    logic [TIME_W-1:0] exp_mem  [DEPTH];
    logic [TIME_W-1:0] del_mem  [DEPTH];

    always_ff @(posedge clk)
    begin
        if (write)
        begin
            addr_mem[widx] <= in_item.peer_address;
            exp_mem[widx]  <= in_item.expiry_time;
            del_mem[widx]  <= in_item.delivery_time;
        end
    end

    assign addr_hit = (addr_mem[ridx] == find_addr);
    assign expired  = (exp_mem[ridx] < now);
    assign key      = del_mem[ridx];

endmodule
`default_nettype wire

@@ rtl/peer_ranging_table_core.sv @@
`default_nettype none
// Peer ranging table: up to TABLE_DEPTH peer entries threaded as a used list
// and a LIFO free list. Each input item on the cmd channel is one command:
// insert, find by address, clear expired entries, or sort by delivery time.
// Results leave on the rsp channel, one item per result; last_result marks
// the final item of a command.
// Both channels use valid and stall; an item moves at an edge where valid
// is high and stall is low. The block works on one command at a time and
// raises cmd_stall until the last result has been taken.
// Insert answers in the cycle after acceptance; find and clear walk the
// used list one entry per cycle. Sort is an insertion sort over the used
// list, then gives one result per cycle while rsp_stall is low.
// Reset empties the table: all entries are free, entry zero first. Entry
// contents are undefined until written. A stalled result holds steady and
// the sequencer waits for it.
module peer_ranging_table_core #(
    parameter int unsigned TABLE_DEPTH = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    output logic                    cmd_stall,
    input  wire prt_pkg::cmd_item_t cmd,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output prt_pkg::rsp_item_t      rsp
);
    import prt_pkg::*;

    localparam int unsigned PW = $clog2(TABLE_DEPTH) + 1;

    logic          dp_write;
    logic [PW-2:0] dp_widx;
    logic [PW-2:0] dp_ridx;
    logic          dp_addr_hit;
    logic          dp_expired;
    logic [31:0]   dp_key;
    logic [15:0]   find_addr_reg;
    logic [31:0]   now_reg;

    // The command fields for the walk are held here for the datapath.
    always_ff @(posedge clk)
    begin
        if (cmd_valid && !cmd_stall)
        begin
            find_addr_reg <= cmd.peer_address;
            now_reg       <= cmd.current_time;
        end
    end

    prt_ctrl #(.DEPTH(TABLE_DEPTH), .PW(PW)) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (cmd_valid),
        .in_stall    (cmd_stall),
        .in_item     (cmd),
        .out_valid   (rsp_valid),
        .out_stall   (rsp_stall),
        .out_item    (rsp),
        .dp_write    (dp_write),
        .dp_widx     (dp_widx),
        .dp_ridx     (dp_ridx),
        .dp_addr_hit (dp_addr_hit),
        .dp_expired  (dp_expired),
        .dp_key      (dp_key)
    );

    prt_dp #(.DEPTH(TABLE_DEPTH), .PW(PW)) u_dp (
        .clk       (clk),
        .in_item   (cmd),
        .write     (dp_write),
        .widx      (dp_widx),
        .ridx      (dp_ridx),
        .find_addr (find_addr_reg),
        .now       (now_reg),
        .addr_hit  (dp_addr_hit),
        .expired   (dp_expired),
        .key       (dp_key)
    );

`ifndef SYNTHESIS
    // No new command while a result is still waiting.
    a_no_accept_with_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> cmd_stall) else $error("command taken with result pending");
    // A result without index_valid never carries an index.
    a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.index_valid) |-> (rsp.entry_index == '0))
        else $error("stray entry index");
    // table_changed only comes with a plain final result.
    a_changed: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.table_changed) |-> (rsp.last_result && !rsp.index_valid))
        else $error("bad clear result");
`endif

endmodule
`default_nettype wire

@@ tb/peer_ranging_table_core_tb.sv @@
`default_nettype none
module peer_ranging_table_core_tb;
    import prt_pkg::*;

    localparam int DEPTH = 16;
    localparam int NIL = DEPTH;

    logic clk;
    logic rst_n;
    logic cmd_valid;
    logic cmd_stall;
    cmd_item_t cmd;
    logic rsp_valid;
    logic rsp_stall;
    rsp_item_t rsp;

    peer_ranging_table_core #(.TABLE_DEPTH(DEPTH)) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd(cmd),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

    // Predicted copy of the table: links, list heads and the entry contents.
    int unsigned next_link[DEPTH];
    int unsigned free_top;
    int unsigned used_top;
    logic [ADDR_W-1:0] peer_addr[DEPTH];
    logic [TIME_W-1:0] peer_expiry[DEPTH];
    logic [TIME_W-1:0] peer_delivery[DEPTH];
    int used_count;

    cmd_item_t pending_cmds[$];
    rsp_item_t expected_rsps[$];
    int errors;
    int cmds_sent;
    int rsps_seen;
    int quiet_phase;
    bit hold_cmds;
    int cmd_gap;
    int rsp_gap;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic rsp_item_t make_rsp(int unsigned idx, bit valid, bit changed,
                                           bit last);
        rsp_item_t r;
        r.entry_index = valid ? idx[3:0] : '0;
        r.index_valid = valid;
        r.table_changed = changed;
        r.last_result = last;
        return r;
    endfunction

    // Apply one accepted command to the predicted table and queue the results it causes.
    task automatic predict_table_cmd(input cmd_item_t c);
        int unsigned idx;
        int unsigned prev;
        int unsigned nxt;
        int unsigned head;
        int unsigned pre;
        int unsigned at;
        bit changed;
        int n;
        case (kind_t'(c.kind))
            KIND_INSERT:
            begin
                idx = free_top;
                if (idx < DEPTH)
                begin
                    free_top = next_link[idx];
                    next_link[idx] = used_top;
                    used_top = idx;
                    peer_addr[idx] = c.peer_address;
                    peer_expiry[idx] = c.expiry_time;
                    peer_delivery[idx] = c.delivery_time;
                    used_count++;
                end
                expected_rsps.push_back(make_rsp(idx, idx < DEPTH, 1'b0, 1'b1));
            end
            KIND_FIND:
            begin
                idx = used_top;
                for (int s = 0; s < DEPTH && idx < DEPTH; s++)
                begin
                    if (peer_addr[idx] == c.peer_address)
                        break;
                    idx = next_link[idx];
                end
                expected_rsps.push_back(make_rsp(idx, idx < DEPTH, 1'b0, 1'b1));
            end
            KIND_CLEAR:
            begin
                // Expired entries go back onto the free list in walk order.
                prev = NIL;
                idx = used_top;
                changed = 1'b0;
                for (int s = 0; s < DEPTH && idx < DEPTH; s++)
                begin
                    nxt = next_link[idx];
                    if (peer_expiry[idx] < c.current_time)
                    begin
                        if (prev < DEPTH)
                            next_link[prev] = nxt;
                        else
                            used_top = nxt;
                        next_link[idx] = free_top;
                        free_top = idx;
                        used_count--;
                        changed = 1'b1;
                    end
                    else
                        prev = idx;
                    idx = nxt;
                end
                expected_rsps.push_back(make_rsp(0, 1'b0, changed, 1'b1));
            end
            default:
            begin
                // Insertion sort; on equal delivery ticks the later entry goes first.
                head = used_top;
                if (head < DEPTH)
                begin
                    idx = next_link[head];
                    next_link[head] = NIL;
                    for (int s = 0; s < DEPTH && idx < DEPTH; s++)
                    begin
                        nxt = next_link[idx];
                        if (peer_delivery[idx] <= peer_delivery[head])
                        begin
                            next_link[idx] = head;
                            head = idx;
                        end
                        else
                        begin
                            pre = head;
                            at = next_link[head];
                            for (int k = 0; k < DEPTH && at < DEPTH
                                 && peer_delivery[idx] > peer_delivery[at]; k++)
                            begin
                                pre = at;
                                at = next_link[at];
                            end
                            next_link[idx] = at;
                            next_link[pre] = idx;
                        end
                        idx = nxt;
                    end
                    used_top = head;
                end
                idx = used_top;
                if (idx >= DEPTH)
                    expected_rsps.push_back(make_rsp(0, 1'b0, 1'b0, 1'b1));
                else
                begin
                    n = 0;
                    while (n < MAX_EMIT && n < DEPTH && idx < DEPTH)
                    begin
                        nxt = next_link[idx];
                        expected_rsps.push_back(make_rsp(idx, 1'b1, 1'b0,
                            nxt >= DEPTH || n + 1 >= MAX_EMIT || n + 1 >= DEPTH));
                        n++;
                        idx = nxt;
                    end
                end
            end
        endcase
    endtask

    function automatic cmd_item_t table_cmd(kind_t k, logic [ADDR_W-1:0] a,
                                            logic [TIME_W-1:0] e,
                                            logic [TIME_W-1:0] d,
                                            logic [TIME_W-1:0] t);
        cmd_item_t c;
        c.kind = k;
        c.peer_address = a;
        c.expiry_time = e;
        c.delivery_time = d;
        c.current_time = t;
        return c;
    endfunction

    function automatic logic [TIME_W-1:0] rand_tick();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 40);
            1: return 32'hFFFF_FFFF - $urandom_range(0, 40);
            default: return $urandom;
        endcase
    endfunction

    // Driver: hands out queued items, pausing in random bursts and, on request,
    // until the block has drained every outstanding result.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            cmd <= '0;
            cmd_gap <= 0;
        end
        else if (!(cmd_valid && cmd_stall))
        begin
            if (cmd_valid)
            begin
                predict_table_cmd(cmd);
                cmds_sent <= cmds_sent + 1;
            end
            if (cmd_gap > 0)
            begin
                cmd_valid <= 1'b0;
                cmd_gap <= cmd_gap - 1;
            end
            else if (pending_cmds.size() == 0 || (hold_cmds && expected_rsps.size() != 0))
                cmd_valid <= 1'b0;
            else if (!quiet_phase && $urandom_range(0, 7) == 0)
            begin
                cmd_valid <= 1'b0;
                cmd_gap <= $urandom_range(0, 9);
            end
            else
            begin
                cmd_valid <= 1'b1;
                cmd <= pending_cmds.pop_front();
            end
        end
    end

    // Monitor: compares each taken result with the oldest prediction and
    // throttles the result channel with random stall bursts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            rsp_gap <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                rsps_seen <= rsps_seen + 1;
                if (expected_rsps.size() == 0)
                begin
                    $error("unexpected result item %p", rsp);
                    errors++;
                end
                else
                begin
                    rsp_item_t want;
                    want = expected_rsps.pop_front();
                    if (rsp.entry_index !== want.entry_index)
                    begin
                        $error("entry_index expected %0d actual %0d",
                               want.entry_index, rsp.entry_index);
                        errors++;
                    end
                    if (rsp.index_valid !== want.index_valid)
                    begin
                        $error("index_valid expected %0d actual %0d",
                               want.index_valid, rsp.index_valid);
                        errors++;
                    end
                    if (rsp.table_changed !== want.table_changed)
                    begin
                        $error("table_changed expected %0d actual %0d",
                               want.table_changed, rsp.table_changed);
                        errors++;
                    end
                    if (rsp.last_result !== want.last_result)
                    begin
                        $error("last_result expected %0d actual %0d",
                               want.last_result, rsp.last_result);
                        errors++;
                    end
                end
            end
            if (rsp_gap > 0)
                rsp_gap <= rsp_gap - 1;
            else if (!quiet_phase && $urandom_range(0, 7) == 0)
            begin
                rsp_stall <= 1'b1;
                rsp_gap <= $urandom_range(0, 9);
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    initial
    begin
        #3_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        int unsigned addr_pool[8];
        int burst;
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        cmd = '0;
        rsp_stall = 1'b0;
        errors = 0;
        cmds_sent = 0;
        rsps_seen = 0;
        quiet_phase = 0;
        hold_cmds = 1'b0;
        for (int i = 0; i < DEPTH; i++)
        begin
            next_link[i] = i + 1;
            peer_addr[i] = '0;
            peer_expiry[i] = '0;
            peer_delivery[i] = '0;
        end
        free_top = 0;
        used_top = NIL;
        used_count = 0;

        // Directed part: empty-table cases, field extremes, a full table,
        // equal delivery ticks, and a clear that removes nothing.
        pending_cmds.push_back(table_cmd(KIND_SORT, 16'h0, 0, 0, 0));
        pending_cmds.push_back(table_cmd(KIND_FIND, 16'hFFFF, 0, 0, 0));
        pending_cmds.push_back(table_cmd(KIND_CLEAR, 16'h0, 0, 0, 32'hFFFF_FFFF));
        for (int i = 0; i < DEPTH; i++)
            pending_cmds.push_back(table_cmd(KIND_INSERT,
                (i == 0) ? 16'hFFFF : i[15:0],
                (i % 2) ? 32'hFFFF_FFFF : i, (i < 4) ? 32'd7 : 32'hFFFF_FFFF - i, 0));
        pending_cmds.push_back(table_cmd(KIND_INSERT, 16'h1234, 5, 5, 0));
        pending_cmds.push_back(table_cmd(KIND_FIND, 16'hFFFF, 0, 0, 0));
        pending_cmds.push_back(table_cmd(KIND_SORT, 0, 0, 0, 0));
        pending_cmds.push_back(table_cmd(KIND_CLEAR, 0, 0, 0, 0));
        pending_cmds.push_back(table_cmd(KIND_CLEAR, 0, 0, 0, 32'hFFFF_FFFF));
        pending_cmds.push_back(table_cmd(KIND_SORT, 0, 0, 0, 0));

        // Random part: insert-heavy bursts from a small address pool so finds hit.
        for (int i = 0; i < 8; i++)
            addr_pool[i] = $urandom_range(0, 16'hFFFF);
        for (int n = 0; n < 360; n++)
        begin
            burst = $urandom_range(0, 99);
            pending_cmds.push_back(table_cmd(
                (burst < 45) ? KIND_INSERT : (burst < 70) ? KIND_FIND :
                (burst < 85) ? KIND_CLEAR : KIND_SORT,
                ADDR_W'(($urandom_range(0, 3) != 0) ? addr_pool[$urandom_range(0, 7)]
                                                    : $urandom),
                rand_tick(), ($urandom_range(0, 3) == 0) ? 32'd100 : rand_tick(),
                rand_tick()));
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Pause once mid-run until everything outstanding has come back.
        wait (cmds_sent >= 150);
        hold_cmds = 1'b1;
        wait (expected_rsps.size() == 0 && !cmd_valid);
        repeat (3) @(posedge clk);
        hold_cmds = 1'b0;

        // The last stretch runs with no idling on either side.
        wait (pending_cmds.size() < 60);
        quiet_phase = 1;
        wait (pending_cmds.size() == 0 && !cmd_valid);
        wait (expected_rsps.size() == 0);
        repeat (DEPTH * DEPTH + 40) @(posedge clk);

        $display("Ran %0d table commands (insert, find, clear, sort) with %0d results,",
                 cmds_sent, rsps_seen);
        $display("including a full table, empty sorts and random stalls on both sides.");
        if (errors == 0 && expected_rsps.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire
